[hw/rtl/hmq_pkg.sv]
// Shared types and constants of the binary min-heap queue.
// Holds the request and status codes, the sequencer states and the result record.
// Depends on nothing; every other file of the block but hmq_mem imports it.
package hmq_pkg;

    localparam int HMQ_KEY_BITS     = 32;
    localparam int HMQ_CAPACITY     = 256;
    localparam int HMQ_PAYLOAD_BITS = 16;

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWIM,
        S_POP_LOAD,
        S_SINK,
        S_PLACE,
        S_RESP
    } hmq_state_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [HMQ_KEY_BITS-1:0] key;
    } hmq_res_t;

endpackage

[hw/rtl/hmq_mem.sv]
// Heap entry store: one write port and two read ports with registered read data.
// Each entry packs a key above its payload. No package dependency.
module hmq_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int EW    = 48
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [EW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [EW-1:0] rdata_a,
    output logic [EW-1:0] rdata_b
);

    logic [EW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[hw/rtl/hmq_ctrl.sv]
// Heap sequencer: decodes requests, walks the sift-up and sift-down paths level by
// level through the entry store, and keeps the entry count. Uses hmq_pkg and hmq_mem.
module hmq_ctrl
    import hmq_pkg::*;
#(
    parameter int CAPACITY     = HMQ_CAPACITY,
    parameter int PAYLOAD_BITS = HMQ_PAYLOAD_BITS,
    localparam int IW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_req_type,
    input  logic [HMQ_KEY_BITS-1:0] s_key,
    input  logic [PAYLOAD_BITS-1:0] s_payload,
    output logic                    res_valid,
    input  logic                    out_free,
    output hmq_res_t                res,
    output logic [PAYLOAD_BITS-1:0] res_payload,
    output logic [CW-1:0]           res_count
);

    localparam int KW = HMQ_KEY_BITS;
    localparam int PW = PAYLOAD_BITS;
    localparam int EW = KW + PW;
    localparam int XW = IW + 2;

    hmq_state_t    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [KW-1:0] item_key_reg, item_key_next;
    logic [PW-1:0] item_pay_reg, item_pay_next;
    logic [1:0]    status_reg, status_next;
    logic [KW-1:0] okey_reg, okey_next;
    logic [PW-1:0] opay_reg, opay_next;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [KW-1:0] mem_wkey;
    logic [PW-1:0] mem_wpay;
    logic [IW-1:0] mem_raddr_a, mem_raddr_b;
    logic [EW-1:0] rdata_a, rdata_b;
    logic [KW-1:0] rkey_a, rkey_b;
    logic [PW-1:0] rpay_a, rpay_b;

    logic          accept;
    logic          is_full, is_empty;
    logic [CW-1:0] cnt_m1, cnt_half;
    logic [IW-1:0] par_cnt, last_idx;
    logic [IW-1:0] pos_m1, par_pos, par_m1, par_of_par;
    logic          swim_less;
    logic [XW-1:0] cnt_x, l_x, r_x, cl_x, cr_x;
    logic          r_ok, take_r, take_l, cl_ok;
    logic [IW-1:0] child;

    hmq_mem #(
        .DEPTH (CAPACITY),
        .AW    (IW),
        .EW    (EW)
    ) u_mem (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   ({mem_wkey, mem_wpay}),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign rkey_a = rdata_a[EW-1:PW];
    assign rpay_a = rdata_a[PW-1:0];
    assign rkey_b = rdata_b[EW-1:PW];
    assign rpay_b = rdata_b[PW-1:0];

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);

    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_half = cnt_m1 >> 1;
    assign par_cnt  = cnt_half[IW-1:0];
    assign last_idx = cnt_m1[IW-1:0];

    assign pos_m1     = pos_reg - IW'(1);
    assign par_pos    = pos_m1 >> 1;
    assign par_m1     = par_pos - IW'(1);
    assign par_of_par = par_m1 >> 1;
    assign swim_less  = item_key_reg < rkey_a;

    assign cnt_x  = XW'(count_reg);
    assign l_x    = XW'({pos_reg, 1'b1});
    assign r_x    = l_x + XW'(1);
    assign r_ok   = r_x < cnt_x;
    assign take_r = r_ok && (rkey_b < item_key_reg) && (rkey_b < rkey_a);
    assign take_l = !take_r && (rkey_a < item_key_reg);
    assign child  = take_r ? r_x[IW-1:0] : l_x[IW-1:0];
    assign cl_x   = XW'({child, 1'b1});
    assign cr_x   = cl_x + XW'(1);
    assign cl_ok  = cl_x < cnt_x;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_req_type)
                        REQ_PUSH: state_next = (is_full || is_empty) ? S_RESP : S_SWIM;
                        REQ_POP:  state_next = is_empty ? S_RESP : S_POP_LOAD;
                        default:  state_next = S_RESP;
                    endcase
                end
            end
            S_SWIM: begin
                if (!swim_less) begin
                    state_next = S_RESP;
                end else if (par_pos == '0) begin
                    state_next = S_PLACE;
                end
            end
            S_POP_LOAD: begin
                if (count_reg == '0) begin
                    state_next = S_RESP;
                end else if (count_reg == CW'(1)) begin
                    state_next = S_PLACE;
                end else begin
                    state_next = S_SINK;
                end
            end
            S_SINK: begin
                if (!(take_r || take_l)) begin
                    state_next = S_RESP;
                end else if (!cl_ok) begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: state_next = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        count_next    = count_reg;
        pos_next      = pos_reg;
        item_key_next = item_key_reg;
        item_pay_next = item_pay_reg;
        status_next   = status_reg;
        okey_next     = okey_reg;
        opay_next     = opay_reg;
        mem_we        = 1'b0;
        mem_waddr     = pos_reg;
        mem_wkey      = item_key_reg;
        mem_wpay      = item_pay_reg;
        mem_raddr_a   = '0;
        mem_raddr_b   = '0;
        res_valid     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    status_next   = ST_OK;
                    okey_next     = '0;
                    opay_next     = '0;
                    item_key_next = s_key;
                    item_pay_next = s_payload;
                    case (s_req_type)
                        REQ_PUSH: begin
                            if (is_full) begin
                                status_next = ST_FULL;
                            end else begin
                                count_next  = count_reg + CW'(1);
                                pos_next    = count_reg[IW-1:0];
                                mem_raddr_a = par_cnt;
                                if (is_empty) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = '0;
                                    mem_wkey  = s_key;
                                    mem_wpay  = s_payload;
                                end
                            end
                        end
                        REQ_POP: begin
                            if (is_empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                count_next  = cnt_m1;
                                mem_raddr_a = '0;
                                mem_raddr_b = last_idx;
                            end
                        end
                        REQ_CLEAR: count_next = '0;
                        default: ;
                    endcase
                end
            end
            S_SWIM: begin
                mem_we = 1'b1;
                if (swim_less) begin
                    mem_wkey    = rkey_a;
                    mem_wpay    = rpay_a;
                    pos_next    = par_pos;
                    mem_raddr_a = par_of_par;
                end
            end
            S_POP_LOAD: begin
                okey_next     = rkey_a;
                opay_next     = rpay_a;
                item_key_next = rkey_b;
                item_pay_next = rpay_b;
                pos_next      = '0;
                mem_raddr_a   = IW'(1);
                mem_raddr_b   = IW'(2);
            end
            S_SINK: begin
                mem_we = 1'b1;
                if (take_r || take_l) begin
                    mem_wkey    = take_r ? rkey_b : rkey_a;
                    mem_wpay    = take_r ? rpay_b : rpay_a;
                    pos_next    = child;
                    mem_raddr_a = cl_x[IW-1:0];
                    mem_raddr_b = cr_x[IW-1:0];
                end
            end
            S_PLACE: mem_we = 1'b1;
            S_RESP:  res_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        pos_reg      <= pos_next;
        item_key_reg <= item_key_next;
        item_pay_reg <= item_pay_next;
        status_reg   <= status_next;
        okey_reg     <= okey_next;
        opay_reg     <= opay_next;
    end

    assign res.status  = status_reg;
    assign res.key     = okey_reg;
    assign res_payload = opay_reg;
    assign res_count   = count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_req_type == REQ_PUSH && !is_full)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("accepted push did not add an entry");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_req_type == REQ_POP && !is_empty)
        |=> count_reg == $past(count_reg) - CW'(1))
        else $error("accepted pop did not remove an entry");

    a_write_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> XW'(mem_waddr) < XW'(count_next))
        else $error("store write outside the occupied part of the heap");

    a_swim_not_root: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SWIM |-> pos_reg != '0)
        else $error("sift-up compare started at the root");
`endif

endmodule

[hw/rtl/binary_min_heap_queue.sv]
// Top level of the binary min-heap queue: sequencer plus a registered result stage.
// Uses hmq_pkg and hmq_ctrl.
//
// Every request (push, pop minimum, clear) gives exactly one result with a status,
// the popped key and payload (zero unless a pop succeeds) and the entry count after
// the request. Clear, refused requests and a push into an empty heap go straight to
// the result. Any other push lets the entry climb level by level; a pop reads the
// root and the last entry, then lets the moved entry sink level by level, unless it
// removes the last entry. Each heap level is one compare step against data read
// from the entry store, which has one write port and two read ports. The store needs
// no clearing after reset; only entries below the count are ever used. A new request
// is taken while the last result still waits in the output register.
module binary_min_heap_queue
    import hmq_pkg::*;
#(
    parameter int CAPACITY     = HMQ_CAPACITY,
    parameter int PAYLOAD_BITS = HMQ_PAYLOAD_BITS,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_req_type,
    input  logic [HMQ_KEY_BITS-1:0] s_key,
    input  logic [PAYLOAD_BITS-1:0] s_payload,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output logic [HMQ_KEY_BITS-1:0] m_out_key,
    output logic [PAYLOAD_BITS-1:0] m_out_payload,
    output logic [CW-1:0]           m_count
);

    logic                    res_valid;
    logic                    out_free;
    hmq_res_t                res;
    logic [PAYLOAD_BITS-1:0] res_payload;
    logic [CW-1:0]           res_count;

    logic                    m_valid_reg, m_valid_next;
    hmq_res_t                m_res_reg;
    logic [PAYLOAD_BITS-1:0] m_pay_reg;
    logic [CW-1:0]           m_count_reg;
    logic                    load;

    hmq_ctrl #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_key       (s_key),
        .s_payload   (s_payload),
        .res_valid   (res_valid),
        .out_free    (out_free),
        .res         (res),
        .res_payload (res_payload),
        .res_count   (res_count)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign load     = res_valid && out_free;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (load) begin
            m_res_reg   <= res;
            m_pay_reg   <= res_payload;
            m_count_reg <= res_count;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_res_reg.status;
    assign m_out_key     = m_res_reg.key;
    assign m_out_payload = m_pay_reg;
    assign m_count       = m_count_reg;

endmodule

[sim/heap_queue_monitor.sv]
// Watches both channels of the binary min-heap queue, keeps its own copy of the heap
// and checks every result transfer against the response it predicts.
// Depends on hmq_pkg for the request and status codes and the capacity.
module heap_queue_monitor
    import hmq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_key,
    input  logic [15:0] s_payload,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [31:0] m_out_key,
    input  logic [15:0] m_out_payload,
    input  logic [8:0]  m_count,
    output int          fail_count,
    output int          outstanding
);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] key;
        logic [15:0] payload;
        logic [8:0]  count;
    } heap_response_t;

    heap_response_t response_queue[$];
    logic [31:0]    heap_key [HMQ_CAPACITY];
    logic [15:0]    heap_pay [HMQ_CAPACITY];
    int             heap_size = 0;
    int             fails = 0;
    int             backlog = 0;
    int             responses_seen = 0;

    assign fail_count  = fails;
    assign outstanding = backlog;

    function automatic void swap_entries(int a, int b);
        logic [31:0] k;
        logic [15:0] p;
        k           = heap_key[a];
        p           = heap_pay[a];
        heap_key[a] = heap_key[b];
        heap_pay[a] = heap_pay[b];
        heap_key[b] = k;
        heap_pay[b] = p;
    endfunction

    function automatic heap_response_t apply_heap_request(logic [1:0] req, logic [31:0] key,
                                                          logic [15:0] pay);
        heap_response_t res;
        int pos;
        int up;
        int l;
        int r;
        bit done;
        res  = '0;
        done = 1'b0;
        case (req)
            REQ_PUSH: begin
                if (heap_size >= HMQ_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    pos           = heap_size;
                    heap_key[pos] = key;
                    heap_pay[pos] = pay;
                    heap_size++;
                    while (pos > 0 && !done) begin
                        up = (pos - 1) >> 1;
                        if (heap_key[pos] < heap_key[up]) begin
                            swap_entries(pos, up);
                            pos = up;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
            end
            REQ_POP: begin
                if (heap_size == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.key     = heap_key[0];
                    res.payload = heap_pay[0];
                    heap_key[0] = heap_key[heap_size-1];
                    heap_pay[0] = heap_pay[heap_size-1];
                    heap_size--;
                    pos = 0;
                    while (!done) begin
                        l = 2 * pos + 1;
                        r = l + 1;
                        if (l >= heap_size) begin
                            done = 1'b1;
                        end else if (r < heap_size && heap_key[r] < heap_key[pos]
                                     && heap_key[r] < heap_key[l]) begin
                            swap_entries(r, pos);
                            pos = r;
                        end else if (heap_key[l] < heap_key[pos]) begin
                            swap_entries(l, pos);
                            pos = l;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
            end
            REQ_CLEAR: begin
                heap_size = 0;
            end
            default: begin
            end
        endcase
        res.count = heap_size[8:0];
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("Mismatch on result %0d: %s is %0h, expected %0h",
                 responses_seen, field, got, want);
        fails++;
    endtask

    always @(posedge aclk) begin : watch
        heap_response_t want;
        if (!aresetn) begin
            response_queue.delete();
            heap_size = 0;
            backlog <= 0;
        end else begin
            if (s_valid && s_ready) begin
                response_queue.push_back(apply_heap_request(s_req_type, s_key, s_payload));
            end
            if (m_valid && m_ready) begin
                if (response_queue.size() == 0) begin
                    $display("Result transfer %0d arrived with no request waiting",
                             responses_seen);
                    fails++;
                end else begin
                    want = response_queue.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", 32'(m_status), 32'(want.status));
                    if (m_out_key !== want.key)
                        report_mismatch("out_key", m_out_key, want.key);
                    if (m_out_payload !== want.payload)
                        report_mismatch("out_payload", 32'(m_out_payload), 32'(want.payload));
                    if (m_count !== want.count)
                        report_mismatch("count", 32'(m_count), 32'(want.count));
                end
                responses_seen++;
            end
            backlog <= response_queue.size();
        end
    end

endmodule

[sim/tb_binary_min_heap_queue.sv]
// Testbench top of the binary min-heap queue: clock, reset, request traffic and verdict.
// Depends on hmq_pkg, binary_min_heap_queue and heap_queue_monitor.
module tb_binary_min_heap_queue;
    import hmq_pkg::*;

    localparam logic [1:0] REQ_UNUSED    = 2'd3;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         PHASE_ITEMS   = 200;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type    = REQ_PUSH;
    logic [31:0] s_key         = '0;
    logic [15:0] s_payload     = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_out_key;
    logic [15:0] m_out_payload;
    logic [8:0]  m_count;

    int fail_count;
    int outstanding;
    int send_idle     = 0;
    int stall_pct     = 0;
    int hold_ticket   = 0;
    int hold_served   = 0;
    int requests_sent = 0;

    binary_min_heap_queue i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_key         (s_key),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_key     (m_out_key),
        .m_out_payload (m_out_payload),
        .m_count       (m_count)
    );

    heap_queue_monitor i_monitor (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_key         (s_key),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_key     (m_out_key),
        .m_out_payload (m_out_payload),
        .m_count       (m_count),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : result_sink
        forever begin
            if (hold_ticket != hold_served) begin
                hold_served = hold_ticket;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
                @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [31:0] key_sample();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($urandom_range(7));
            2: return {16'($urandom_range(3)), 16'($urandom)};
            default: return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
        endcase
    endfunction

    task automatic offer_request(input logic [1:0] req, input logic [31:0] key,
                                 input logic [15:0] pay);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_key      <= key;
        s_payload  <= pay;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (req != REQ_UNUSED) requests_sent++;
    endtask

    task automatic push_random();
        offer_request(REQ_PUSH, key_sample(), 16'($urandom));
    endtask

    task automatic wait_for_responses();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic directed_requests();
        offer_request(REQ_POP, $urandom, 16'($urandom));
        offer_request(REQ_PUSH, 32'hFFFF_FFFF, 16'hFFFF);
        offer_request(REQ_PUSH, 32'h0, 16'h0000);
        offer_request(REQ_PUSH, 32'h5, 16'h1111);
        offer_request(REQ_PUSH, 32'h5, 16'h2222);
        offer_request(REQ_PUSH, 32'h9, 16'h3333);
        offer_request(REQ_POP, 32'h0, 16'h0);
        offer_request(REQ_POP, 32'h0, 16'h0);
        offer_request(REQ_POP, 32'h0, 16'h0);
        offer_request(REQ_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
        offer_request(REQ_POP, 32'h0, 16'h0);
        offer_request(REQ_POP, 32'h0, 16'h0);
        offer_request(REQ_POP, 32'h0, 16'h0);
        // Two equal children below the entry that moves to the root after the pop.
        offer_request(REQ_PUSH, 32'h1, 16'h0101);
        offer_request(REQ_PUSH, 32'h5, 16'h0A0A);
        offer_request(REQ_PUSH, 32'h5, 16'h0B0B);
        offer_request(REQ_PUSH, 32'h9, 16'h0909);
        offer_request(REQ_POP, 32'h0, 16'h0);
        offer_request(REQ_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
        offer_request(REQ_POP, 32'h0, 16'h0);
        offer_request(REQ_PUSH, 32'h8000_0000, 16'h8000);
        offer_request(REQ_PUSH, 32'h7FFF_FFFF, 16'h7FFF);
        offer_request(REQ_POP, 32'h0, 16'h0);
        offer_request(REQ_CLEAR, 32'h0, 16'h0);
    endtask

    task automatic fill_and_empty();
        offer_request(REQ_CLEAR, $urandom, 16'($urandom));
        repeat (HMQ_CAPACITY + 2) push_random();
        repeat (HMQ_CAPACITY + 2) offer_request(REQ_POP, $urandom, 16'($urandom));
    endtask

    task automatic random_traffic();
        int unsigned pick;
        int unsigned n;
        int unsigned j;
        int unsigned r;
        pick = $urandom_range(99);
        if (pick < 70) begin
            n = $urandom_range(24, 1);
            repeat (n) push_random();
            j = $urandom_range(n + 4, n / 2);
            repeat (j) offer_request(REQ_POP, $urandom, 16'($urandom));
        end else if (pick < 90) begin
            n = $urandom_range(16, 1);
            repeat (n) begin
                r = $urandom_range(99);
                if (r < 50)
                    push_random();
                else if (r < 88)
                    offer_request(REQ_POP, $urandom, 16'($urandom));
                else if (r < 94)
                    offer_request(REQ_CLEAR, $urandom, 16'($urandom));
                else
                    offer_request(REQ_UNUSED, $urandom, 16'($urandom));
            end
        end else begin
            n = $urandom_range(8, 1);
            repeat (n) offer_request(2'($urandom_range(3)), $urandom, 16'($urandom));
        end
    endtask

    initial begin : stimulus
        int phase;
        int phase_start;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_requests();
        wait_for_responses();
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle = 0;
                    stall_pct <= 0;
                end
                1: begin
                    send_idle = 45;
                    stall_pct <= 0;
                end
                2: begin
                    send_idle = 0;
                    stall_pct <= 45;
                end
                default: begin
                    send_idle = 35;
                    stall_pct <= 35;
                end
            endcase
            if (phase == 1) fill_and_empty();
            if (phase == 2) begin
                // The sink holds off while requests keep coming, so the input stalls.
                hold_ticket <= hold_ticket + 1;
                repeat (40) push_random();
            end
            phase_start = requests_sent;
            while (requests_sent - phase_start < PHASE_ITEMS) random_traffic();
            wait_for_responses();
        end
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
